### rtl/lrusf_pkg.sv
// Shared constants for the laser range undistortion and shadow filter.
// Holds field widths, register indexes and register reset values.
// Has no dependencies; the interfaces and the top level use it.
package lrusf_pkg;

   // Field widths that are fixed by the data formats.
   localparam int SAMPLE_W    = 22;
   localparam int FRAC_W      = 16;
   localparam int TRIG_W      = 17;
   localparam int TAN_W       = 24;
   localparam int ALPHA_W     = 24;
   localparam int BETA_W      = 25;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Register indexes on the configuration port.
   localparam csr_index_type CSR_MIN_FLOOR  = 3'd0;
   localparam csr_index_type CSR_SENSOR_MIN = 3'd1;
   localparam csr_index_type CSR_SENSOR_MAX = 3'd2;
   localparam csr_index_type CSR_STEP_SINE  = 3'd3;
   localparam csr_index_type CSR_STEP_COS   = 3'd4;
   localparam csr_index_type CSR_SHADOW_TAN = 3'd5;
   localparam csr_index_type CSR_ALPHA      = 3'd6;
   localparam csr_index_type CSR_BETA       = 3'd7;

   // One meter in Q6.16.
   localparam logic [FRAC_W:0] ONE_METRE = 17'd65536;

   // Register values after reset.
   localparam logic [SAMPLE_W-1:0]      RST_SENSOR_MAX = 22'd1966080;
   localparam logic [TRIG_W-1:0]        RST_STEP_COS   = 17'd65536;
   localparam logic [TAN_W-1:0]         RST_SHADOW_TAN = 24'd653170;
   localparam logic [ALPHA_W-1:0]       RST_ALPHA      = 24'd2136530;
   localparam logic signed [BETA_W-1:0] RST_BETA       = -25'sd1366580;

endpackage

### rtl/lrusf_if.sv
// Request and response channel interfaces of the shadow filter.
// Each carries valid, ready and the payload fields; widths come from lrusf_pkg.
// Depends on lrusf_pkg.
interface lrusf_req_if;
   logic                             valid;
   logic                             ready;
   logic [lrusf_pkg::SAMPLE_W-1:0]   range_sample;
   logic                             scan_end;

   modport source (output valid, range_sample, scan_end, input ready);
   modport sink   (input valid, range_sample, scan_end, output ready);
endinterface

interface lrusf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lrusf_pkg::SAMPLE_W-1:0]   range_out;
   logic                             marked_invalid;
   logic                             scan_end_out;

   modport source (output valid, range_out, marked_invalid, scan_end_out, input ready);
   modport sink   (input valid, range_out, marked_invalid, scan_end_out, output ready);
endinterface

### rtl/laser_range_undistort_shadow_filter_top.sv
// Laser range undistortion and shadow filter, top level.
// Depends on lrusf_pkg and the channel interfaces in lrusf_if.sv.
//
// Usage: range samples of one scan enter in order on req_chan, each a request
// of range_sample (Q6.16 meters) and scan_end. A sample above the range floor
// gets the radial correction added; then each neighboring pair is checked for
// a shadow edge and both samples of a hit are replaced by the invalid marker.
// Results leave on rsp_chan one sample late; a request with scan_end flushes
// the held sample and itself, so a scan never pairs with the next one.
// Configuration is written through csr_we/csr_index/csr_wdata while idle.
//
// Flow: one request is worked on at a time, with W = RANGE_BITS.
// A corrected sample runs the square, the divide and the add; a sample with a
// held neighbor then runs the cosine, sine and tangent products of the test.
// An uncorrected sample skips the correction steps; a first sample, the products.
// The bit-serial restoring divider (40 quotient bits) and the shift-add
// multiplier (one multiplier bit per cycle) set the length of these steps.
// Reset clears the held sample and restores the register defaults.
// A stalled receiver holds the result register; the next request is still
// taken and runs until its own result needs that register.
module laser_range_undistort_shadow_filter_top #(
   parameter int RANGE_BITS = 22
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lrusf_req_if.sink                             req_chan,
   lrusf_rsp_if.source                           rsp_chan,
   input  logic                                  csr_we,
   input  logic [lrusf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lrusf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IW      = lrusf_pkg::SAMPLE_W;
   localparam int FW      = lrusf_pkg::FRAC_W;
   localparam int W       = RANGE_BITS;
   localparam logic [63:0] RANGE_MASK = (64'd1 << RANGE_BITS) - 64'd1;
   localparam int SQ_W    = 2 * IW;
   localparam int DNW     = SQ_W + 2;
   localparam int NUM_W   = lrusf_pkg::ALPHA_W + FW;
   localparam int SUM_W   = NUM_W + 1;
   localparam int YW      = W + lrusf_pkg::TRIG_W;
   localparam int PW      = W + lrusf_pkg::TRIG_W + lrusf_pkg::TAN_W;
   localparam int BW      = (W > lrusf_pkg::TAN_W) ? W : lrusf_pkg::TAN_W;
   localparam int CNT_MAX = (NUM_W > BW) ? NUM_W : BW;
   localparam int CW      = $clog2(CNT_MAX + 1);
   localparam int MKW     = 34;

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SQR      = 4'd1;
   localparam logic [3:0] S_DEN      = 4'd2;
   localparam logic [3:0] S_DIV      = 4'd3;
   localparam logic [3:0] S_SUM      = 4'd4;
   localparam logic [3:0] S_TEST     = 4'd5;
   localparam logic [3:0] S_MCOS     = 4'd6;
   localparam logic [3:0] S_MSIN     = 4'd7;
   localparam logic [3:0] S_MTAN     = 4'd8;
   localparam logic [3:0] S_OUT_PREV = 4'd9;
   localparam logic [3:0] S_OUT_CUR  = 4'd10;

   // Configuration registers.
   logic [IW-1:0]                          floor_ff;
   logic [IW-1:0]                          smin_ff;
   logic [IW-1:0]                          smax_ff;
   logic [lrusf_pkg::TRIG_W-1:0]           sine_ff;
   logic [lrusf_pkg::TRIG_W-1:0]           cosine_ff;
   logic [lrusf_pkg::TAN_W-1:0]            tan_ff;
   logic [lrusf_pkg::ALPHA_W-1:0]          alpha_ff;
   logic signed [lrusf_pkg::BETA_W-1:0]    beta_ff;

   // Control and datapath registers.
   logic [3:0]       state_ff, state_in;
   logic [W-1:0]     cur_ff, cur_in;
   logic             end_ff, end_in;
   logic             hit_ff, hit_in;
   logic [W-1:0]     prev_ff, prev_in;
   logic             prev_inv_ff, prev_inv_in;
   logic             have_prev_ff, have_prev_in;
   logic [PW-1:0]    acc_ff, acc_in;
   logic [PW-1:0]    mcand_ff, mcand_in;
   logic [BW-1:0]    mplier_ff, mplier_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DNW-2:0]   denom_ff, denom_in;
   logic [DNW-2:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [YW-1:0]    y_ff, y_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]    rsp_range_ff, rsp_range_in;
   logic             rsp_inv_ff, rsp_inv_in;
   logic             rsp_end_ff, rsp_end_in;

   // Combinational helpers.
   logic [IW-1:0]          raw_masked;
   logic [IW-1:0]          floor_eff;
   logic                   mul_busy;
   logic [PW-1:0]          mul_sum;
   logic signed [DNW-1:0]  den_s;
   logic                   den_pos;
   logic [DNW-1:0]         rem_sh;
   logic [DNW-1:0]         rem_diff;
   logic                   rem_ge;
   logic [SUM_W-1:0]       sum_w;
   logic                   sum_sat;
   logic [YW-1:0]          c16;
   logic [YW-1:0]          pc;
   logic [YW-1:0]          y_abs;
   logic                   hit_now;
   logic [MKW-1:0]         marker_wide;
   logic [W-1:0]           marker;
   logic                   slot_free;

   // Input masking and the effective range floor.
   assign raw_masked = req_chan.range_sample & IW'(RANGE_MASK);
   assign floor_eff  = (smin_ff > floor_ff) ? smin_ff : floor_ff;

   // Shift-add multiplier step: one multiplier bit per cycle.
   assign mul_busy = ((state_ff == S_SQR) || (state_ff == S_MCOS) ||
                      (state_ff == S_MSIN) || (state_ff == S_MTAN)) && (cnt_ff != '0);
   assign mul_sum  = acc_ff + (mplier_ff[0] ? mcand_ff : '0);

   // Denominator r^2 + beta, signed.
   assign den_s   = $signed({2'b00, acc_ff[SQ_W-1:0]}) + DNW'(beta_ff);
   assign den_pos = !den_s[DNW-1] && (den_s != '0);

   // Restoring divider step: one quotient bit per cycle.
   assign rem_sh   = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, denom_ff};
   assign rem_diff = rem_sh - {1'b0, denom_ff};

   // Corrected range with saturation.
   assign sum_w   = SUM_W'(num_ff) + SUM_W'(cur_ff);
   assign sum_sat = sum_w > SUM_W'(RANGE_MASK);

   // Shadow test terms: |cur*2^16 - prev*cos| and the final compare.
   assign c16     = YW'({cur_ff, {FW{1'b0}}});
   assign pc      = YW'(acc_ff);
   assign y_abs   = (c16 > pc) ? (c16 - pc) : (pc - c16);
   assign hit_now = PW'({y_ff, {FW{1'b0}}}) > acc_ff;

   // Invalid marker is the maximum range plus one meter, saturated.
   assign marker_wide = MKW'(smax_ff) + MKW'(lrusf_pkg::ONE_METRE);
   assign marker      = (marker_wide > MKW'(RANGE_MASK)) ? W'(RANGE_MASK) : W'(marker_wide);

   // The result register can take a new result.
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Channel outputs.
   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.range_out      = rsp_range_ff;
   assign rsp_chan.marked_invalid = rsp_inv_ff;
   assign rsp_chan.scan_end_out   = rsp_end_ff;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff  <= '0;
         smin_ff   <= '0;
         smax_ff   <= lrusf_pkg::RST_SENSOR_MAX;
         sine_ff   <= '0;
         cosine_ff <= lrusf_pkg::RST_STEP_COS;
         tan_ff    <= lrusf_pkg::RST_SHADOW_TAN;
         alpha_ff  <= lrusf_pkg::RST_ALPHA;
         beta_ff   <= lrusf_pkg::RST_BETA;
      end else if (csr_we) begin
         unique case (csr_index)
            lrusf_pkg::CSR_MIN_FLOOR:  floor_ff  <= csr_wdata[IW-1:0];
            lrusf_pkg::CSR_SENSOR_MIN: smin_ff   <= csr_wdata[IW-1:0];
            lrusf_pkg::CSR_SENSOR_MAX: smax_ff   <= csr_wdata[IW-1:0];
            lrusf_pkg::CSR_STEP_SINE:  sine_ff   <= csr_wdata[lrusf_pkg::TRIG_W-1:0];
            lrusf_pkg::CSR_STEP_COS:   cosine_ff <= csr_wdata[lrusf_pkg::TRIG_W-1:0];
            lrusf_pkg::CSR_SHADOW_TAN: tan_ff    <= csr_wdata[lrusf_pkg::TAN_W-1:0];
            lrusf_pkg::CSR_ALPHA:      alpha_ff  <= csr_wdata[lrusf_pkg::ALPHA_W-1:0];
            lrusf_pkg::CSR_BETA:       beta_ff   <= $signed(csr_wdata[lrusf_pkg::BETA_W-1:0]);
            default: ;
         endcase
      end
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      hit_in       = hit_ff;
      prev_in      = prev_ff;
      prev_inv_in  = prev_inv_ff;
      have_prev_in = have_prev_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      denom_in     = denom_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_range_in = rsp_range_ff;
      rsp_inv_in   = rsp_inv_ff;
      rsp_end_in   = rsp_end_ff;

      // Multiplier step shared by the square and the shadow products.
      if (mul_busy) begin
         acc_in    = mul_sum;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - CW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cur_in = W'(raw_masked);
               end_in = req_chan.scan_end;
               if (raw_masked > floor_eff) begin
                  mcand_in  = PW'(raw_masked);
                  mplier_in = BW'(raw_masked);
                  acc_in    = '0;
                  cnt_in    = CW'(IW);
                  state_in  = S_SQR;
               end else begin
                  state_in = S_TEST;
               end
            end
         end
         S_SQR: begin
            if (cnt_ff == '0) begin
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            if (den_pos) begin
               denom_in = den_s[DNW-2:0];
               num_in   = {alpha_ff, {FW{1'b0}}};
               rem_in   = '0;
               cnt_in   = CW'(NUM_W);
               state_in = S_DIV;
            end else begin
               state_in = S_TEST;
            end
         end
         S_DIV: begin
            if (cnt_ff != '0) begin
               rem_in = rem_ge ? rem_diff[DNW-2:0] : rem_sh[DNW-2:0];
               num_in = {num_ff[NUM_W-2:0], rem_ge};
               cnt_in = cnt_ff - CW'(1);
            end else begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cur_in   = sum_sat ? W'(RANGE_MASK) : W'(sum_w);
            state_in = S_TEST;
         end
         S_TEST: begin
            if (have_prev_ff) begin
               mcand_in  = PW'(cosine_ff);
               mplier_in = BW'(prev_ff);
               acc_in    = '0;
               cnt_in    = CW'(W);
               state_in  = S_MCOS;
            end else begin
               hit_in   = 1'b0;
               state_in = S_OUT_CUR;
            end
         end
         S_MCOS: begin
            if (cnt_ff == '0) begin
               y_in      = y_abs;
               mcand_in  = PW'(sine_ff);
               mplier_in = BW'(prev_ff);
               acc_in    = '0;
               cnt_in    = CW'(W);
               state_in  = S_MSIN;
            end
         end
         S_MSIN: begin
            if (cnt_ff == '0) begin
               mcand_in  = acc_ff;
               mplier_in = BW'(tan_ff);
               acc_in    = '0;
               cnt_in    = CW'(lrusf_pkg::TAN_W);
               state_in  = S_MTAN;
            end
         end
         S_MTAN: begin
            if (cnt_ff == '0) begin
               hit_in   = hit_now;
               state_in = S_OUT_PREV;
            end
         end
         S_OUT_PREV: begin
            // The held sample goes out first, marked if either test hit it.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_range_in = IW'((prev_inv_ff || hit_ff) ? marker : prev_ff);
               rsp_inv_in   = prev_inv_ff || hit_ff;
               rsp_end_in   = 1'b0;
               state_in     = S_OUT_CUR;
            end
         end
         S_OUT_CUR: begin
            if (end_ff) begin
               // End of scan: emit the current sample and drop the held one.
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_range_in = IW'(hit_ff ? marker : cur_ff);
                  rsp_inv_in   = hit_ff;
                  rsp_end_in   = 1'b1;
                  prev_in      = '0;
                  prev_inv_in  = 1'b0;
                  have_prev_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end else begin
               prev_in      = cur_ff;
               prev_inv_in  = hit_ff;
               have_prev_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Register update; only control state is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         prev_inv_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_inv_ff  <= prev_inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      end_ff       <= end_in;
      hit_ff       <= hit_in;
      prev_ff      <= prev_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      cnt_ff       <= cnt_in;
      denom_ff     <= denom_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      y_ff         <= y_in;
      rsp_range_ff <= rsp_range_in;
      rsp_inv_ff   <= rsp_inv_in;
      rsp_end_ff   <= rsp_end_in;
   end

`ifndef SYNTHESIS
   // An accepted request always starts work.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != S_IDLE))
      else $error("accepted request did not leave idle");

   // A shadow hit needs a held neighbor.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT_CUR) && !have_prev_ff) |-> !hit_ff)
      else $error("shadow hit without a held sample");

   // The divider remainder stays below the denominator.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < denom_ff))
      else $error("divider remainder out of range");

   // Flushing a scan leaves no held sample behind.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT_CUR) && end_ff && slot_free) |=> !have_prev_ff)
      else $error("held sample survived the end of scan");
`endif

endmodule

### tb/lrusf_scan_checker.sv
// Scoreboard for the laser range shadow filter: predicts every filtered sample.
// Snoops the request, response and register ports and compares field by field.
// Depends on lrusf_pkg and the channel interfaces in lrusf_if.sv.
module lrusf_scan_checker
   import lrusf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lrusf_req_if                   req_chan,
   lrusf_rsp_if                   rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     outstanding
);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] range_out;
      logic                marked_invalid;
      logic                scan_end_out;
   } filtered_sample_type;

   // Samples the filter still owes, oldest first.
   filtered_sample_type filtered_q[$];
   int errors = 0;

   // Local copy of the register file.
   logic [SAMPLE_W-1:0]      floor_sw;
   logic [SAMPLE_W-1:0]      sensor_min;
   logic [SAMPLE_W-1:0]      sensor_max;
   logic [TRIG_W-1:0]        sine;
   logic [TRIG_W-1:0]        cosine;
   logic [TAN_W-1:0]         tan_limit;
   logic [ALPHA_W-1:0]       alpha;
   logic signed [BETA_W-1:0] beta;

   // The sample held back while waiting for its right-hand neighbor.
   logic [SAMPLE_W-1:0] held_range;
   logic                held_invalid;
   logic                held_valid;

   // Radial correction: adds alpha/(beta + r^2) above the floor, saturating.
   function automatic logic [SAMPLE_W-1:0] undistort(input logic [SAMPLE_W-1:0] r);
      logic [SAMPLE_W-1:0] floor_eff;
      longint              denom;
      logic [63:0]         total;
      floor_eff = (sensor_min > floor_sw) ? sensor_min : floor_sw;
      if (r <= floor_eff) return r;
      denom = longint'(r) * longint'(r) + longint'(beta);
      if (denom <= 0) return r;
      total = 64'(r) + ((64'(alpha) << FRAC_W) / 64'(denom));
      return (total > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : total[SAMPLE_W-1:0];
   endfunction

   // Shadow edge between neighbors: |cur - prev*cos| > prev*sin*tan, exact.
   function automatic logic shadow_edge(input logic [SAMPLE_W-1:0] prev,
                                        input logic [SAMPLE_W-1:0] cur);
      logic [127:0] rotated, scaled, spread;
      rotated = 128'(prev) * 128'(cosine);
      scaled  = 128'(cur) << FRAC_W;
      spread  = (scaled > rotated) ? scaled - rotated : rotated - scaled;
      return (spread << FRAC_W) > 128'(prev) * 128'(sine) * 128'(tan_limit);
   endfunction

   // The marker is one meter beyond the sensor maximum, saturated.
   function automatic logic [SAMPLE_W-1:0] invalid_marker();
      logic [SAMPLE_W:0] marker;
      marker = {1'b0, sensor_max} + (SAMPLE_W+1)'(ONE_METRE);
      return (marker > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : marker[SAMPLE_W-1:0];
   endfunction

   function automatic filtered_sample_type emit(input logic [SAMPLE_W-1:0] range_v,
                                                input logic invalid, input logic last);
      filtered_sample_type s;
      s.range_out      = invalid ? invalid_marker() : range_v;
      s.marked_invalid = invalid;
      s.scan_end_out   = last;
      return s;
   endfunction

   function automatic void compare_field(input string name,
                                         input logic [SAMPLE_W-1:0] expected_v,
                                         input logic [SAMPLE_W-1:0] actual_v);
      if (actual_v !== expected_v) begin
         $error("%s: expected %0d, actual %0d", name, expected_v, actual_v);
         errors++;
      end
   endfunction

   // Track register writes, accepted requests and accepted responses.
   always @(posedge clock) begin : track
      filtered_sample_type want;
      logic [SAMPLE_W-1:0] cur;
      logic                hit;
      if (reset) begin
         floor_sw     = '0;
         sensor_min   = '0;
         sensor_max   = RST_SENSOR_MAX;
         sine         = '0;
         cosine       = RST_STEP_COS;
         tan_limit    = RST_SHADOW_TAN;
         alpha        = RST_ALPHA;
         beta         = RST_BETA;
         held_range   = '0;
         held_invalid = 1'b0;
         held_valid   = 1'b0;
         filtered_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_FLOOR:  floor_sw   = csr_wdata[SAMPLE_W-1:0];
               CSR_SENSOR_MIN: sensor_min = csr_wdata[SAMPLE_W-1:0];
               CSR_SENSOR_MAX: sensor_max = csr_wdata[SAMPLE_W-1:0];
               CSR_STEP_SINE:  sine       = csr_wdata[TRIG_W-1:0];
               CSR_STEP_COS:   cosine     = csr_wdata[TRIG_W-1:0];
               CSR_SHADOW_TAN: tan_limit  = csr_wdata[TAN_W-1:0];
               CSR_ALPHA:      alpha      = csr_wdata[ALPHA_W-1:0];
               CSR_BETA:       beta       = csr_wdata[BETA_W-1:0];
               default: ;
            endcase
         end

         // A new sample releases the held one and is held itself unless the scan ends.
         if (req_chan.valid && req_chan.ready) begin
            cur = undistort(req_chan.range_sample);
            hit = 1'b0;
            if (held_valid) begin
               hit = shadow_edge(held_range, cur);
               filtered_q.insert(filtered_q.size(),
                                 emit(held_range, held_invalid || hit, 1'b0));
            end
            if (req_chan.scan_end) begin
               filtered_q.insert(filtered_q.size(), emit(cur, hit, 1'b1));
               held_range   = '0;
               held_invalid = 1'b0;
               held_valid   = 1'b0;
            end else begin
               held_range   = cur;
               held_invalid = hit;
               held_valid   = 1'b1;
            end
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            if (filtered_q.size() == 0) begin
               $error("Unexpected response: range_out %0d, marked_invalid %0d, scan_end_out %0d",
                      rsp_chan.range_out, rsp_chan.marked_invalid, rsp_chan.scan_end_out);
               errors++;
            end else begin
               want = filtered_q.pop_front();
               compare_field("range_out", want.range_out, rsp_chan.range_out);
               compare_field("marked_invalid", SAMPLE_W'(want.marked_invalid),
                             SAMPLE_W'(rsp_chan.marked_invalid));
               compare_field("scan_end_out", SAMPLE_W'(want.scan_end_out),
                             SAMPLE_W'(rsp_chan.scan_end_out));
            end
         end
      end
      error_count <= errors;
      outstanding <= filtered_q.size();
   end

endmodule

### tb/tb_laser_range_undistort_shadow_filter_top.sv
// Testbench top for the laser range shadow filter: clock, reset, stimulus, verdict.
// Drives directed and random scans under several register settings with random idling.
// Depends on lrusf_pkg, lrusf_if.sv, lrusf_scan_checker and the filter top level.
module tb_laser_range_undistort_shadow_filter_top;
   import lrusf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int PHASE_SAMPLES  = 190;
   localparam int RANDOM_PHASES  = 8;
   localparam int REG_COUNT      = 8;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_LONG_STALL} ready_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic [CSR_DATA_W-1:0]  cfg_image [REG_COUNT];
   int                     error_count;
   int                     outstanding;
   int                     quiet_cycles = 0;
   int                     burst_left = 0;
   ready_mode_type         ready_mode = READY_ALWAYS;
   int                     mode_left = 0;
   int                     hold_left = 0;

   lrusf_req_if req_chan();
   lrusf_rsp_if rsp_chan();

   laser_range_undistort_shadow_filter_top #(
      .RANGE_BITS (SAMPLE_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lrusf_scan_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   // End the run if neither channel moves a request or response for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response backpressure: switches between always ready, coin flips and long stalls.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 2));
         mode_left  <= $urandom_range(50, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_chan.ready <= 1'b1;
         READY_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
         default: begin
            if (hold_left == 0) begin
               rsp_chan.ready <= !rsp_chan.ready;
               hold_left <= rsp_chan.ready ? $urandom_range(1, 30) : $urandom_range(1, 6);
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   // Write the whole register image on consecutive cycles; call at a falling edge.
   task automatic load_config();
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= cfg_image[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one request and hold it until accepted; inserts a gap at the end of a burst.
   task automatic push_sample(input logic [SAMPLE_W-1:0] sample, input logic last);
      req_chan.valid        <= 1'b1;
      req_chan.range_sample <= sample;
      req_chan.scan_end     <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_chan.valid        <= 1'b0;
         req_chan.range_sample <= SAMPLE_W'($urandom);
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Stop sending until every predicted sample has come back, then settle.
   task automatic wait_results(input int settle);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int                  phase_count;
      int                  scan_count;
      int                  scan_len;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] delta;
      logic [SAMPLE_W-1:0] floor_eff;

      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_MIN_FLOOR;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.range_sample = '0;
      req_chan.scan_end     = 1'b0;
      rsp_chan.ready        = 1'b0;
      scan_count            = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register defaults: single sample scans, equal and unequal pairs,
      // a denominator that is not positive, and a hit inside a longer scan.
      push_sample('0, 1'b1);
      push_sample(SAMPLE_MAX, 1'b1);
      push_sample(22'd65536, 1'b0);
      push_sample(22'd65536, 1'b1);
      push_sample(22'd65536, 1'b0);
      push_sample(22'd131072, 1'b1);
      push_sample(22'd1000, 1'b0);
      push_sample(22'd1000, 1'b1);
      push_sample(22'd200000, 1'b0);
      push_sample(22'd200000, 1'b0);
      push_sample(22'd300000, 1'b1);
      wait_results(SETTLE_CYCLES);

      // Upper extremes: largest correction saturates, zero threshold marks any step.
      cfg_image[CSR_MIN_FLOOR]  = '0;
      cfg_image[CSR_SENSOR_MIN] = '0;
      cfg_image[CSR_SENSOR_MAX] = 25'd4128767;
      cfg_image[CSR_STEP_SINE]  = 25'd65536;
      cfg_image[CSR_STEP_COS]   = '0;
      cfg_image[CSR_SHADOW_TAN] = '0;
      cfg_image[CSR_ALPHA]      = 25'd16777215;
      cfg_image[CSR_BETA]       = '0;
      load_config();
      push_sample(22'd1, 1'b1);
      push_sample(SAMPLE_MAX, 1'b0);
      push_sample(SAMPLE_MAX, 1'b1);
      push_sample('0, 1'b0);
      push_sample('0, 1'b1);
      wait_results(SETTLE_CYCLES);

      // Sensor floor at the top, trig values above one, saturated marker, most negative beta.
      cfg_image[CSR_MIN_FLOOR]  = '0;
      cfg_image[CSR_SENSOR_MIN] = 25'(SAMPLE_MAX);
      cfg_image[CSR_SENSOR_MAX] = 25'(SAMPLE_MAX);
      cfg_image[CSR_STEP_SINE]  = 25'd131071;
      cfg_image[CSR_STEP_COS]   = 25'd131071;
      cfg_image[CSR_SHADOW_TAN] = 25'd16777215;
      cfg_image[CSR_ALPHA]      = '0;
      cfg_image[CSR_BETA]       = 25'h1000000;
      load_config();
      push_sample(SAMPLE_MAX, 1'b0);
      push_sample(22'd4194302, 1'b1);
      push_sample('0, 1'b0);
      push_sample(22'd65536, 1'b1);
      wait_results(SETTLE_CYCLES);

      // Random settings, each with a run of mostly smooth scans and some edges and noise.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         cfg_image[CSR_MIN_FLOOR]  = ($urandom_range(0, 3) == 0) ?
                                     25'($urandom_range(0, SAMPLE_MAX)) :
                                     25'($urandom_range(0, 131072));
         cfg_image[CSR_SENSOR_MIN] = ($urandom_range(0, 3) == 0) ?
                                     25'($urandom_range(0, SAMPLE_MAX)) :
                                     25'($urandom_range(0, 131072));
         cfg_image[CSR_SENSOR_MAX] = 25'($urandom_range(0, 4128767));
         cfg_image[CSR_STEP_SINE]  = ($urandom_range(0, 3) == 0) ?
                                     25'($urandom_range(0, 65536)) :
                                     25'($urandom_range(0, 4000));
         cfg_image[CSR_STEP_COS]   = ($urandom_range(0, 3) == 0) ?
                                     25'($urandom_range(0, 65536)) :
                                     25'(65536 - $urandom_range(0, 300));
         cfg_image[CSR_SHADOW_TAN] = ($urandom_range(0, 3) == 0) ?
                                     25'($urandom_range(0, 16777215)) :
                                     25'($urandom_range(300000, 1500000));
         cfg_image[CSR_ALPHA]      = 25'($urandom_range(0, 16777215));
         cfg_image[CSR_BETA]       = 25'($urandom);
         load_config();
         floor_eff = (cfg_image[CSR_SENSOR_MIN][SAMPLE_W-1:0] >
                      cfg_image[CSR_MIN_FLOOR][SAMPLE_W-1:0]) ?
                     cfg_image[CSR_SENSOR_MIN][SAMPLE_W-1:0] :
                     cfg_image[CSR_MIN_FLOOR][SAMPLE_W-1:0];
         phase_count = 0;
         while (phase_count < PHASE_SAMPLES) begin
            // Now and then let the filter run completely dry between scans.
            if (scan_count % 25 == 3) wait_results(0);
            scan_count++;
            scan_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 24);
            sample = SAMPLE_W'($urandom_range(20000, 1500000));
            for (int k = 0; k < scan_len; k++) begin
               case ($urandom_range(0, 11))
                  0: sample = SAMPLE_W'($urandom);
                  1: sample = SAMPLE_W'($urandom_range(0, 1500000));
                  2: sample = floor_eff + SAMPLE_W'($urandom_range(0, 1));
                  default: begin
                     delta = SAMPLE_W'($urandom_range(0, 400));
                     if ($urandom_range(0, 1) == 1)
                        sample = (sample > SAMPLE_MAX - delta) ? SAMPLE_MAX : sample + delta;
                     else
                        sample = (sample < delta) ? '0 : sample - delta;
                  end
               endcase
               if (k > 0 && $urandom_range(0, 49) == 0) wait_results(0);
               push_sample(sample, k == scan_len - 1);
               phase_count++;
            end
         end
         wait_results(SETTLE_CYCLES);
      end

      if (error_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/lrusf_pkg.sv
rtl/lrusf_if.sv
rtl/laser_range_undistort_shadow_filter_top.sv
tb/lrusf_scan_checker.sv
tb/tb_laser_range_undistort_shadow_filter_top.sv
